// File: design/assert_macros.svh
// Assertion macros used by the top level of the pattern replace block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent holds in a cycle, so the consequent must hold in the same cycle.
`define CHK_SAME(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The antecedent holds in a cycle, so the consequent must hold in the next cycle.
`define CHK_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: design/fmbpr_pkg.sv
// Package of constants and types for the byte pattern replace block.
`default_nettype none

package fmbpr_pkg;

    localparam int MAX_PATTERN_DEF = 8;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 4;
    localparam int SEL_W           = 3;
    localparam int CFG_W           = 64;
    localparam int CFG_IDX_W       = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH      = 2'd2;

    // Contents of one cell of the chain.
    typedef struct packed {
        logic              valid;
        logic              done;
        logic              last;
        logic              rep;
        logic [BYTE_W-1:0] data;
    } link_t;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic shift;
        logic pop;
        logic do_rep;
        logic new_rep;
        logic flush;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: design/first_match_byte_pattern_replace_top.sv
// Top level of the first-match byte pattern search and replace block.
//
// Usage: the bytes of a region arrive on the input channel (data_byte, with
// last_byte set on the final one), moved by in_valid and in_stall; an item is
// taken at a clock edge with in_valid high and in_stall low. Rewritten bytes
// leave on the output channel (out_byte, out_last, was_replaced) under
// out_valid and out_stall in the same way, in their original order. Throughput
// is one item per cycle in steady state unless the receiver stalls. A byte
// stays in the window until pattern_length - 1 younger bytes have arrived;
// it then leaves once it is oldest and the output register is free. The last
// byte of a region releases the whole window, which drains at one item per
// cycle unless the receiver stalls, while the next region is already being
// taken in. The chain has MAX_PATTERN + 1 cells; in_stall is raised only
// while the oldest cell is occupied, which takes a long receiver stall. A
// stalled output item holds its value. Reset empties the chain and sets the
// registers to pattern 0, replacement 0 and length 1. Configuration must be
// written through cfg_we, cfg_index and cfg_wdata only while no region is in
// flight; the block does not enforce this. Unknown indexes are ignored.
`default_nettype none

module first_match_byte_pattern_replace_top #(
    parameter int MAX_PATTERN = fmbpr_pkg::MAX_PATTERN_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [fmbpr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fmbpr_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [fmbpr_pkg::BYTE_W-1:0]       data_byte,
    input  logic                               last_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [fmbpr_pkg::BYTE_W-1:0]       out_byte,
    output logic                               out_last,
    output logic                               was_replaced
);

`include "assert_macros.svh"

    localparam int N_CELLS = MAX_PATTERN + 1;
    localparam logic [fmbpr_pkg::LEN_W-1:0] MAX_LEN = fmbpr_pkg::LEN_W'(MAX_PATTERN);

    // Configuration registers.
    logic [fmbpr_pkg::CFG_W-1:0]   pattern_reg;
    logic [fmbpr_pkg::CFG_W-1:0]   replacement_reg;
    logic [fmbpr_pkg::LEN_W-1:0]   plen_reg;
    logic [fmbpr_pkg::LEN_W-1:0]   eff_len;

    logic                          match_done_reg;
    logic                          match_done_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [fmbpr_pkg::BYTE_W-1:0]  out_byte_reg;
    logic                          out_last_reg;
    logic                          out_rep_reg;

    fmbpr_pkg::cell_ctrl_t         ctrl;
    fmbpr_pkg::link_t              head;
    fmbpr_pkg::link_t              links [N_CELLS];
    fmbpr_pkg::link_t              top_link;
    logic [N_CELLS-1:0]            hits;
    logic [N_CELLS-1:0]            tops;
    logic [N_CELLS-1:0]            valid_vec;
    logic                          shift;
    logic                          pop;
    logic                          do_rep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg     <= '0;
            replacement_reg <= '0;
            plen_reg        <= fmbpr_pkg::LEN_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fmbpr_pkg::REG_PATTERN:     pattern_reg     <= cfg_wdata;
                fmbpr_pkg::REG_REPLACEMENT: replacement_reg <= cfg_wdata;
                fmbpr_pkg::REG_LENGTH:      plen_reg        <= cfg_wdata[fmbpr_pkg::LEN_W-1:0];
                default:                    ;
            endcase
        end
    end

    // A length of zero behaves as one, and a length beyond MAX_PATTERN is clamped to it.
    always_comb
    begin
        if (plen_reg == '0)
        begin
            eff_len = fmbpr_pkg::LEN_W'(1);
        end
        else if (plen_reg > MAX_LEN)
        begin
            eff_len = MAX_LEN;
        end
        else
        begin
            eff_len = plen_reg;
        end
    end

    // The oldest cell must be empty before the chain can move up by one.
    assign in_stall = links[N_CELLS-1].valid;
    assign shift    = in_valid & ~in_stall;

    // A match needs every cell within the pattern length to agree, and only
    // the first match of a region is replaced.
    assign do_rep = shift & ~match_done_reg & (&hits);

    assign head.valid = 1'b1;
    assign head.done  = 1'b0;
    assign head.last  = last_byte;
    assign head.rep   = 1'b0;
    assign head.data  = data_byte;

    assign ctrl.shift   = shift;
    assign ctrl.pop     = pop;
    assign ctrl.do_rep  = do_rep;
    assign ctrl.new_rep = last_byte & (match_done_reg | do_rep);
    // The last byte of a region releases every byte still held in the window.
    assign ctrl.flush   = last_byte;

    genvar gi;
    generate
        for (gi = 0; gi < N_CELLS; gi = gi + 1)
        begin : g_cell
            fmbpr_cell #(
                .POS (gi)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .eff_len     (eff_len),
                .pattern     (pattern_reg),
                .replacement (replacement_reg),
                .prev        ((gi == 0) ? head : links[(gi == 0) ? 0 : gi - 1]),
                .prev_top    ((gi == 0) ? 1'b0 : tops[(gi == 0) ? 0 : gi - 1]),
                .nxt_valid   ((gi == N_CELLS - 1) ? 1'b0
                                : links[(gi == N_CELLS - 1) ? gi : gi + 1].valid),
                .cur         (links[gi]),
                .is_top      (tops[gi]),
                .hit         (hits[gi])
            );
            assign valid_vec[gi] = links[gi].valid;
        end
    endgenerate

    // The oldest occupied cell feeds the output register once it has been
    // released from the window.
    always_comb
    begin
        top_link = '0;
        for (int p = 0; p < N_CELLS; p++)
        begin
            if (tops[p])
            begin
                top_link = top_link | links[p];
            end
        end
    end

    assign pop = top_link.valid & top_link.done & (~out_valid_reg | ~out_stall);

    always_comb
    begin
        match_done_next = match_done_reg;
        if (shift)
        begin
            match_done_next = last_byte ? 1'b0 : (match_done_reg | do_rep);
        end
    end

    always_comb
    begin
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_done_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            match_done_reg <= match_done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_byte_reg <= top_link.data;
            out_last_reg <= top_link.last;
            out_rep_reg  <= top_link.rep;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign out_last     = out_last_reg;
    assign was_replaced = out_rep_reg;

    // A stalled output item must never be overwritten by the chain.
    `CHK_SAME(a_no_pop_on_stall, clk, rst_n, out_valid_reg && out_stall, !pop)
    // The end of a region always clears the match flag.
    `CHK_NEXT(a_match_clear, clk, rst_n, shift && last_byte, !match_done_reg)
    // Occupied cells form an unbroken run starting at the youngest cell.
    `CHK_SAME(a_chain_packed, clk, rst_n, 1'b1,
        ((valid_vec + N_CELLS'(1)) & valid_vec) == '0)
    // The replaced flag only ever rides on the final byte of a region.
    `CHK_SAME(a_rep_on_last, clk, rst_n, out_valid && was_replaced, out_last)

endmodule

`default_nettype wire

// File: design/fmbpr_cell.sv
// One cell of the byte chain: holds a byte, compares it and hands it on.
`default_nettype none

module fmbpr_cell #(
    parameter int POS = 0
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  fmbpr_pkg::cell_ctrl_t            ctrl,
    input  logic [fmbpr_pkg::LEN_W-1:0]      eff_len,
    input  logic [fmbpr_pkg::CFG_W-1:0]      pattern,
    input  logic [fmbpr_pkg::CFG_W-1:0]      replacement,
    input  fmbpr_pkg::link_t                 prev,
    input  logic                             prev_top,
    input  logic                             nxt_valid,
    output fmbpr_pkg::link_t                 cur,
    output logic                             is_top,
    output logic                             hit
);

    localparam logic [fmbpr_pkg::LEN_W-1:0] POS_L      = fmbpr_pkg::LEN_W'(POS);
    localparam logic [fmbpr_pkg::LEN_W-1:0] POS_NEXT_L = fmbpr_pkg::LEN_W'(POS + 1);
    localparam logic                        IS_HEAD    = (POS == 0);

    fmbpr_pkg::link_t                   link_reg;
    fmbpr_pkg::link_t                   link_next;
    logic [fmbpr_pkg::LEN_W-1:0]        idx_full;
    logic [fmbpr_pkg::SEL_W-1:0]        sel;
    logic [fmbpr_pkg::BYTE_W-1:0]       pat_byte;
    logic [fmbpr_pkg::BYTE_W-1:0]       rep_byte;
    logic                               in_window;
    logic                               in_match;

    // The incoming byte takes age POS; it lines up with pattern byte L-1-POS.
    assign idx_full  = eff_len - POS_NEXT_L;
    assign sel       = idx_full[fmbpr_pkg::SEL_W-1:0];
    assign pat_byte  = pattern[{sel, 3'b000} +: fmbpr_pkg::BYTE_W];
    assign rep_byte  = replacement[{sel, 3'b000} +: fmbpr_pkg::BYTE_W];
    assign in_match  = (POS_L < eff_len);
    assign in_window = prev.valid & ~prev.done;
    assign hit       = ~in_match | (in_window & (prev.data == pat_byte));

    assign cur    = link_reg;
    assign is_top = link_reg.valid & ~nxt_valid;

    always_comb
    begin
        link_next = link_reg;
        if (ctrl.shift)
        begin
            link_next.valid = prev.valid & ~(prev_top & ctrl.pop);
            link_next.data  = (ctrl.do_rep && in_match) ? rep_byte : prev.data;
            // A byte leaves the window once it is too old to be in a match,
            // or at once when the region ends.
            link_next.done  = prev.done | ctrl.flush | (POS_NEXT_L >= eff_len);
            link_next.last  = prev.last;
            link_next.rep   = prev.rep | (IS_HEAD & ctrl.new_rep);
        end
        else if (is_top && ctrl.pop)
        begin
            link_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

endmodule

`default_nettype wire

// File: test/tb_first_match_byte_pattern_replace_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the first-match byte pattern replace block.

module tb_first_match_byte_pattern_replace_top;

    // The longest pattern the block is built for, and the run's time budget.
    localparam int MAX_LEN         = fmbpr_pkg::MAX_PATTERN_DEF;
    localparam int SETTLE_CYCLES   = fmbpr_pkg::MAX_PATTERN_DEF + 4;
    localparam int TAIL_CYCLES     = 2 * fmbpr_pkg::MAX_PATTERN_DEF + 8;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 20;

    // An index that names no register; writes to it must change nothing.
    localparam logic [fmbpr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // One rewritten byte as it leaves the block.
    typedef struct packed {
        logic [fmbpr_pkg::BYTE_W-1:0] data;
        logic                         last;
        logic                         replaced;
    } rewritten_t;

    // The scoreboard keeps its own copy of the search window and of the
    // registers. Each accepted input item is run through the same search
    // as the block, and the bytes that it releases are queued in order.
    // Every output item is then compared with the oldest queued byte.
    class replace_scoreboard;
        logic [fmbpr_pkg::BYTE_W-1:0] held_bytes [MAX_LEN];
        int unsigned                  held;
        bit                           replaced;
        logic [fmbpr_pkg::CFG_W-1:0]  pattern;
        logic [fmbpr_pkg::CFG_W-1:0]  replacement;
        logic [fmbpr_pkg::LEN_W-1:0]  length;
        rewritten_t                   rewritten_q [$];
        int unsigned                  mismatches;

        function new();
            clear_region();
            pattern     = '0;
            replacement = '0;
            length      = 4'd1;
            mismatches  = 0;
        endfunction

        function void clear_region();
            for (int i = 0; i < MAX_LEN; i++)
                held_bytes[i] = '0;
            held     = 0;
            replaced = 1'b0;
        endfunction

        // A length of zero acts as one, anything beyond the build limit as the limit.
        function int unsigned eff_len();
            int unsigned l;
            l = length;
            if (l == 0)
                l = 1;
            if (l > MAX_LEN)
                l = MAX_LEN;
            return l;
        endfunction

        function void write_register(logic [fmbpr_pkg::CFG_IDX_W-1:0] idx,
                                     logic [fmbpr_pkg::CFG_W-1:0] value);
            case (idx)
                fmbpr_pkg::REG_PATTERN:     pattern     = value;
                fmbpr_pkg::REG_REPLACEMENT: replacement = value;
                fmbpr_pkg::REG_LENGTH:      length      = value[fmbpr_pkg::LEN_W-1:0];
                default:                    ;
            endcase
        endfunction

        function void queue_byte(logic [fmbpr_pkg::BYTE_W-1:0] data, logic last, logic rep);
            rewritten_t e;
            e.data     = data;
            e.last     = last;
            e.replaced = rep;
            rewritten_q.push_back(e);
        endfunction

        function void note_byte(logic [fmbpr_pkg::BYTE_W-1:0] data, logic last);
            logic [fmbpr_pkg::BYTE_W-1:0] cand [MAX_LEN];
            int unsigned                  l;
            int unsigned                  n;
            int unsigned                  base;
            int unsigned                  emit;
            bit                           hit;
            l = eff_len();
            for (int i = 0; i < MAX_LEN; i++)
                cand[i] = (i < held) ? held_bytes[i] : 8'h00;
            cand[held] = data;
            n = held + 1;
            if (!replaced && n >= l)
            begin
                hit  = 1'b1;
                base = n - l;
                for (int i = 0; i < l; i++)
                    if (cand[base + i] != pattern[8 * i +: 8])
                        hit = 1'b0;
                if (hit)
                begin
                    for (int i = 0; i < l; i++)
                        cand[base + i] = replacement[8 * i +: 8];
                    replaced = 1'b1;
                end
            end
            if (last)
            begin
                for (int i = 0; i < n; i++)
                    queue_byte(cand[i], i == n - 1, (i == n - 1) && replaced);
                clear_region();
            end
            else
            begin
                emit = (n > l - 1) ? n - (l - 1) : 0;
                for (int i = 0; i < emit; i++)
                    queue_byte(cand[i], 1'b0, 1'b0);
                for (int i = 0; i < MAX_LEN; i++)
                    held_bytes[i] = (i < n - emit) ? cand[emit + i] : 8'h00;
                held = n - emit;
            end
        endfunction

        function void check_byte(logic [fmbpr_pkg::BYTE_W-1:0] data, logic last, logic rep);
            rewritten_t e;
            if (rewritten_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: expected no output item, got byte %h last %b replaced %b",
                         $time, data, last, rep);
                return;
            end
            e = rewritten_q.pop_front();
            if (data !== e.data || last !== e.last || rep !== e.replaced)
            begin
                mismatches++;
                $display("%0t: expected byte %h last %b replaced %b, %s %h last %b replaced %b",
                         $time, e.data, e.last, e.replaced, "got byte", data, last, rep);
            end
        endfunction

        function int unsigned pending();
            return rewritten_q.size();
        endfunction
    endclass

    logic                                clk          = 1'b0;
    logic                                rst_n        = 1'b0;
    logic                                cfg_we       = 1'b0;
    logic [fmbpr_pkg::CFG_IDX_W-1:0]     cfg_index    = '0;
    logic [fmbpr_pkg::CFG_W-1:0]         cfg_wdata    = '0;
    logic                                in_valid     = 1'b0;
    logic                                in_stall;
    logic [fmbpr_pkg::BYTE_W-1:0]        data_byte    = '0;
    logic                                last_byte    = 1'b0;
    logic                                out_valid;
    logic                                out_stall    = 1'b0;
    logic [fmbpr_pkg::BYTE_W-1:0]        out_byte;
    logic                                out_last;
    logic                                was_replaced;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int unsigned tx_idle_pct  = 13;
    int unsigned rx_stall_pct = 55;
    int unsigned cycle_count  = 0;

    replace_scoreboard                   sb;
    logic [fmbpr_pkg::BYTE_W-1:0]        region_q [$];

    first_match_byte_pattern_replace_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .out_last     (out_last),
        .was_replaced (was_replaced)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver side. Signals read straight after the edge still hold their
    // values from before it, so this sees exactly what the block saw. An
    // output item is taken when valid is high and the stall is low; the
    // stall for the next cycle is then drawn at random.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_byte(out_byte, out_last, was_replaced);
        out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    // Watchdog: a hung block or a lost item ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    // Offers one byte, after a random number of idle cycles, and holds it
    // until the block takes it. Valid is only lowered in an idle cycle, so
    // back-to-back items keep it high without a glitch.
    task automatic send_byte(input logic [fmbpr_pkg::BYTE_W-1:0] value, input logic is_last);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        last_byte <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_byte(value, is_last);
    endtask

    // Stops offering items until every expected byte has come out.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Sends the queued region, marking its final byte. Now and then the
    // sender holds back mid-region until the output has caught up.
    task automatic send_queued(inout int unsigned sent);
        for (int i = 0; i < region_q.size(); i++)
        begin
            if ($urandom_range(0, 49) == 0)
                hold_until_drained();
            send_byte(region_q[i], i == region_q.size() - 1);
        end
        sent += region_q.size();
    endtask

    task automatic write_reg(input logic [fmbpr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fmbpr_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        sb.write_register(idx, value);
    endtask

    // Registers change only between regions, once the output has drained
    // and the flush has had time to leave the chain.
    task automatic load_config(input logic [fmbpr_pkg::CFG_W-1:0] pat,
                               input logic [fmbpr_pkg::CFG_W-1:0] rep,
                               input logic [fmbpr_pkg::LEN_W-1:0] len);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(fmbpr_pkg::REG_PATTERN, pat);
        write_reg(fmbpr_pkg::REG_REPLACEMENT, rep);
        write_reg(fmbpr_pkg::REG_LENGTH,
                  {{(fmbpr_pkg::CFG_W - fmbpr_pkg::LEN_W){1'b0}}, len});
        cfg_we <= 1'b0;
    endtask

    // Builds one region around the current pattern. Most regions carry one
    // or two whole copies of it among filler that is often made of pattern
    // bytes, so partial matches are common; others are pure noise, a copy
    // with one bit flipped, or a region too short to hold the pattern.
    task automatic send_random_region(inout int unsigned sent);
        int unsigned l;
        int unsigned span;
        int unsigned kind;
        int unsigned at;
        int unsigned j;
        l    = sb.eff_len();
        kind = $urandom_range(0, 9);
        span = ($urandom_range(0, 7) == 0) ? $urandom_range(1, l) : $urandom_range(l, 2 * l + 8);
        region_q.delete();
        for (int i = 0; i < span; i++)
        begin
            j = $urandom_range(0, l - 1);
            if ($urandom_range(0, 1) == 1)
                region_q.push_back(8'($urandom));
            else
                region_q.push_back(sb.pattern[8 * j +: 8]);
        end
        if (kind < 8 && span >= l)
        begin
            at = $urandom_range(0, span - l);
            for (int i = 0; i < l; i++)
                region_q[at + i] = sb.pattern[8 * i +: 8];
            if (kind == 6)
            begin
                at = $urandom_range(0, span - l);
                for (int i = 0; i < l; i++)
                    region_q[at + i] = sb.pattern[8 * i +: 8];
            end
            else if (kind == 7)
            begin
                j = $urandom_range(0, l - 1);
                region_q[at + j] = region_q[at + j] ^ (8'h01 << $urandom_range(0, 7));
            end
        end
        send_queued(sent);
    endtask

    initial
    begin
        int unsigned directed_items;
        int unsigned phase_items;
        sb = new();
        directed_items = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The pattern is A1 B2 C3 with junk in the unused
        // upper bytes of both registers, which must be ignored.
        load_config(64'hDEAD_BEEF_55C3_B2A1, 64'h0123_4567_8933_2211, 4'd3);
        @(posedge clk);
        write_reg(REG_UNUSED, {$urandom, $urandom});
        cfg_we <= 1'b0;

        // A region shorter than the pattern passes straight through.
        region_q = '{8'hFF};
        send_queued(directed_items);
        // Match at the very start, followed by a trailing byte.
        region_q = '{8'hA1, 8'hB2, 8'hC3, 8'h00};
        send_queued(directed_items);
        // Two matches after a false start: only the first is replaced.
        region_q = '{8'hA1, 8'hA1, 8'hB2, 8'hC3, 8'hA1, 8'hB2, 8'hC3};
        send_queued(directed_items);
        // Match in the final position, ending on the last byte.
        region_q = '{8'h80, 8'hA1, 8'hB2, 8'hC3};
        send_queued(directed_items);

        // A length of zero behaves as a single-byte pattern.
        load_config(64'h0, {64{1'b1}}, 4'd0);
        region_q = '{8'h00, 8'h00};
        send_queued(directed_items);

        // A length beyond the limit behaves as eight bytes; a whole-pattern
        // region then flushes eight items at once.
        load_config(64'h8877_6655_4433_2211, 64'hF0E1_D2C3_B4A5_9687, 4'd15);
        region_q = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88};
        send_queued(directed_items);

        // Random part: each phase sets new registers, taking in both
        // length extremes and the all-zero and all-one patterns. The idle
        // pattern of the two sides swaps a third of the way through and
        // the last phases run with no idling at all.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase < 3)
            begin
                tx_idle_pct  = 13;
                rx_stall_pct = 55;
            end
            else if (phase < 6)
            begin
                tx_idle_pct  = 55;
                rx_stall_pct = 13;
            end
            else
            begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            case (phase)
                0:       load_config({$urandom, $urandom}, {$urandom, $urandom}, 4'd1);
                1:       load_config({$urandom, $urandom}, {$urandom, $urandom}, 4'd8);
                2:       load_config({64{1'b1}}, 64'h0, 4'd0);
                3:       load_config(64'h0, {64{1'b1}}, 4'd15);
                4:       load_config({$urandom, $urandom}, {$urandom, $urandom}, 4'd2);
                5:       load_config({$urandom, $urandom}, {$urandom, $urandom}, 4'd5);
                6:       load_config({$urandom, $urandom}, {$urandom, $urandom}, 4'd3);
                default: load_config({$urandom, $urandom}, {$urandom, $urandom}, 4'd7);
            endcase
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
                send_random_region(phase_items);
        end

        // Let the last flush leave, then watch a while for stray items.
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
